>>> rtl/ibrp_pkg.sv
// Package: types, constants and codes shared by the buffer recycle pool.
package ibrp_pkg;

    localparam int POOL_ENTRIES = 16;
    localparam int HANDLE_BITS  = 16;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
    localparam logic [47:0] SAT48  = 48'hFFFF_FFFF_FFFF;
    localparam logic [32:0] NONE33 = 33'h1_FFFF_FFFF;
    localparam logic [31:0] MAX32  = 32'hFFFF_FFFF;
    localparam logic [15:0] PURGE_AGE_RESET = 16'd10;

    // Register indexes.
    localparam logic [0:0] REG_MAX_IDLE  = 1'b0;
    localparam logic [0:0] REG_PURGE_AGE = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_REUSED  = 3'd0,
        ST_NEW     = 3'd1,
        ST_KEPT    = 3'd2,
        ST_DROPPED = 3'd3,
        ST_TICK    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ACQ_READ,
        S_ACQ_CHECK,
        S_ACQ_SHIFT_READ,
        S_ACQ_SHIFT_WRITE,
        S_PURGE_READ,
        S_PURGE_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] elapsed;
        logic [31:0] request_size;
        logic        dynamic;
        logic [15:0] handle;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_handle;
        logic [4:0]  purged;
        logic [47:0] total_bytes;
        logic [47:0] idle_bytes;
        logic [4:0]  idle_count;
        logic [15:0] live_count;
    } out_beat_t;

    // One idle list entry.
    typedef struct packed {
        logic [HANDLE_BITS-1:0] hnd;
        logic [31:0]            size;
        logic                   dyn;
        logic [31:0]            when;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture input beat
        logic tick_time;   // advance time, latch purge decision
        logic rd;          // read entry at read pointer
        logic acq_check;   // evaluate match on read data
        logic shift_rd;    // read entry rd_ptr+1 for compaction
        logic shift_wr;    // write that entry to rd_ptr
        logic purge_check; // keep or drop read entry
        logic finish;      // apply bookkeeping and emit result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic purge_go;  // purge walk needed
        logic list_end;  // read pointer reached the fill count
        logic match;     // acquire found its entry
        logic shift_end; // compaction finished
    } dp_stat_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? SAT48 : s[47:0];
    endfunction

    function automatic logic [47:0] floor_sub48(input logic [47:0] a, input logic [31:0] b);
        return (a > {16'd0, b}) ? a - {16'd0, b} : 48'd0;
    endfunction

endpackage

>>> rtl/ibrp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ibrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ibrp_ctrl.sv
// Controller state machine of the buffer recycle pool.
module ibrp_ctrl import ibrp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_ACQUIRE: state_next = S_ACQ_READ;
                    CMD_TICK:    state_next = S_PURGE_READ;
                    default:     state_next = S_DONE;
                endcase
            end
            S_ACQ_READ:
            begin
                state_next = stat.list_end ? S_DONE : S_ACQ_CHECK;
            end
            S_ACQ_CHECK:
            begin
                state_next = stat.match ? S_ACQ_SHIFT_READ : S_ACQ_READ;
            end
            S_ACQ_SHIFT_READ:
            begin
                state_next = stat.shift_end ? S_DONE : S_ACQ_SHIFT_WRITE;
            end
            S_ACQ_SHIFT_WRITE:
            begin
                state_next = S_ACQ_SHIFT_READ;
            end
            S_PURGE_READ:
            begin
                state_next = (!stat.purge_go || stat.list_end) ? S_DONE : S_PURGE_CHECK;
            end
            S_PURGE_CHECK:
            begin
                state_next = S_PURGE_READ;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:            cmd.load = start;
            S_DECODE:          cmd.tick_time = 1'b1;
            S_ACQ_READ:        cmd.rd = 1'b1;
            S_ACQ_CHECK:       cmd.acq_check = 1'b1;
            S_ACQ_SHIFT_READ:  cmd.shift_rd = 1'b1;
            S_ACQ_SHIFT_WRITE: cmd.shift_wr = 1'b1;
            S_PURGE_READ:      cmd.rd = stat.purge_go;
            S_PURGE_CHECK:     cmd.purge_check = 1'b1;
            S_DONE:            cmd.finish = 1'b1;
            default:           cmd = '0;
        endcase
    end

endmodule

>>> rtl/ibrp_dp.sv
// Datapath of the buffer recycle pool: idle list memory, totals and result.
module ibrp_dp import ibrp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  in_beat,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [31:0] cfg_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      done,
    output out_beat_t result
);

    in_beat_t    beat_reg;
    logic [31:0] max_idle_reg;
    logic [15:0] purge_age_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] now_reg, now_next;
    logic [32:0] oldest_reg, oldest_next;
    logic [47:0] total_reg, total_next;
    logic [47:0] idle_reg, idle_next;
    logic [15:0] live_reg, live_next;
    logic [HANDLE_BITS-1:0] next_hnd_reg, next_hnd_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [4:0]  gone_reg, gone_next;
    logic        go_reg, go_next;
    logic        found_reg, found_next;
    logic [HANDLE_BITS-1:0] res_hnd_reg, res_hnd_next;
    logic [2:0]  status_reg, status_next;
    out_beat_t   result_reg;
    logic        done_reg;

    logic        we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t      wdata, rdata;
    logic        re;
    logic [32:0] now_sum;
    logic [31:0] age;
    logic [33:0] cap_sum;
    logic        over;

    ibrp_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_ENTRIES)) u_list (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_idle_reg  <= '0;
            purge_age_reg <= PURGE_AGE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_IDLE)
            begin
                max_idle_reg <= cfg_data;
            end
            else
            begin
                purge_age_reg <= cfg_data[15:0];
            end
        end
    end

    // Captured input beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            beat_reg <= in_beat;
        end
    end

    assign stat.cmd       = cmd_t'(beat_reg.command);
    assign stat.purge_go  = go_reg;
    assign stat.list_end  = (rd_ptr_reg >= count_reg);
    assign stat.match     = found_next;
    assign stat.shift_end = (rd_ptr_reg + CNT_W'(1) >= count_reg);

    assign now_sum = {1'b0, now_reg} + {17'd0, beat_reg.elapsed};
    assign age     = now_reg - rdata.when;
    assign cap_sum = {1'b0, idle_reg[32:0]} + {2'b0, beat_reg.request_size};
    assign over    = (max_idle_reg != 32'd0) &&
                     ((idle_reg[47:33] != 15'd0) || (cap_sum > {2'b0, max_idle_reg}));

    // Memory port control.
    always_comb
    begin
        re    = cmd.rd || cmd.shift_rd;
        raddr = cmd.shift_rd ? IDX_W'(rd_ptr_reg + CNT_W'(1)) : IDX_W'(rd_ptr_reg);
        we    = 1'b0;
        waddr = IDX_W'(wr_ptr_reg);
        wdata = rdata;
        if (cmd.shift_wr || (cmd.purge_check && age < {16'd0, purge_age_reg}))
        begin
            we = 1'b1;
        end
        if (cmd.finish && beat_reg.command == CMD_RELEASE && !over &&
            count_reg < CNT_W'(POOL_ENTRIES))
        begin
            we          = 1'b1;
            waddr       = IDX_W'(count_reg);
            wdata.hnd   = HANDLE_BITS'(beat_reg.handle);
            wdata.size  = beat_reg.request_size;
            wdata.dyn   = beat_reg.dynamic;
            wdata.when  = now_reg;
        end
    end

    // Datapath next-state logic.
    always_comb
    begin
        count_next    = count_reg;
        now_next      = now_reg;
        oldest_next   = oldest_reg;
        total_next    = total_reg;
        idle_next     = idle_reg;
        live_next     = live_reg;
        next_hnd_next = next_hnd_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        gone_next     = gone_reg;
        go_next       = go_reg;
        found_next    = found_reg;
        res_hnd_next  = res_hnd_reg;
        status_next   = status_reg;

        if (cmd.load)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            gone_next   = '0;
            found_next  = 1'b0;
            go_next     = 1'b0;
        end
        if (cmd.tick_time && beat_reg.command == CMD_TICK)
        begin
            now_next = now_sum[32] ? MAX32 : now_sum[31:0];
            go_next  = (purge_age_reg != 16'd0) && (oldest_reg != NONE33) &&
                       ((now_next - oldest_reg[31:0]) >= {16'd0, purge_age_reg});
            if (go_next)
            begin
                oldest_next = NONE33;
            end
        end
        if (cmd.rd)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end
        if (cmd.acq_check)
        begin
            if (rdata.dyn == beat_reg.dynamic && rdata.size >= beat_reg.request_size)
            begin
                found_next   = 1'b1;
                res_hnd_next = rdata.hnd;
                idle_next    = floor_sub48(idle_reg, rdata.size);
                rd_ptr_next  = rd_ptr_reg - CNT_W'(1);
                wr_ptr_next  = rd_ptr_reg - CNT_W'(1);
            end
        end
        if (cmd.shift_wr)
        begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
        end
        if (cmd.purge_check)
        begin
            if (age >= {16'd0, purge_age_reg})
            begin
                idle_next  = floor_sub48(idle_reg, rdata.size);
                total_next = floor_sub48(total_reg, rdata.size);
                live_next  = (live_reg != 16'd0) ? live_reg - 16'd1 : 16'd0;
                gone_next  = gone_reg + 5'd1;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                if ({1'b0, rdata.when} < oldest_reg)
                begin
                    oldest_next = {1'b0, rdata.when};
                end
            end
        end
        if (cmd.finish)
        begin
            res_hnd_next = '0;
            status_next  = ST_TICK;
            unique case (cmd_t'(beat_reg.command))
                CMD_TICK:
                begin
                    if (go_reg)
                    begin
                        count_next = wr_ptr_reg;
                    end
                end
                CMD_ACQUIRE:
                begin
                    if (found_reg)
                    begin
                        res_hnd_next = res_hnd_reg;
                        count_next   = count_reg - CNT_W'(1);
                        status_next  = ST_REUSED;
                    end
                    else
                    begin
                        res_hnd_next  = next_hnd_reg;
                        next_hnd_next = next_hnd_reg + HANDLE_BITS'(1);
                        total_next    = sat_add48(total_reg, beat_reg.request_size);
                        if (live_reg != 16'hFFFF)
                        begin
                            live_next = live_reg + 16'd1;
                        end
                        status_next = ST_NEW;
                    end
                end
                CMD_RELEASE:
                begin
                    if (over || count_reg >= CNT_W'(POOL_ENTRIES))
                    begin
                        total_next  = floor_sub48(total_reg, beat_reg.request_size);
                        live_next   = (live_reg != 16'd0) ? live_reg - 16'd1 : 16'd0;
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        idle_next  = sat_add48(idle_reg, beat_reg.request_size);
                        if ({1'b0, now_reg} < oldest_reg)
                        begin
                            oldest_next = {1'b0, now_reg};
                        end
                        status_next = ST_KEPT;
                    end
                end
                default:
                begin
                    status_next = ST_TICK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            now_reg      <= '0;
            oldest_reg   <= NONE33;
            total_reg    <= '0;
            idle_reg     <= '0;
            live_reg     <= '0;
            next_hnd_reg <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            gone_reg     <= '0;
            go_reg       <= 1'b0;
            found_reg    <= 1'b0;
            res_hnd_reg  <= '0;
            status_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            now_reg      <= now_next;
            oldest_reg   <= oldest_next;
            total_reg    <= total_next;
            idle_reg     <= idle_next;
            live_reg     <= live_next;
            next_hnd_reg <= next_hnd_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            gone_reg     <= gone_next;
            go_reg       <= go_next;
            found_reg    <= found_next;
            res_hnd_reg  <= res_hnd_next;
            status_reg   <= status_next;
            done_reg     <= cmd.finish;
        end
    end

    // Result register, loaded from the next values at finish.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.status        <= status_next;
            result_reg.result_handle <= 16'(res_hnd_next);
            result_reg.purged        <= (beat_reg.command == CMD_TICK) ? gone_reg : 5'd0;
            result_reg.total_bytes   <= total_next;
            result_reg.idle_bytes    <= idle_next;
            result_reg.idle_count    <= 5'(count_next);
            result_reg.live_count    <= live_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/idle_buffer_recycle_pool.sv
// Top level of the idle buffer recycle pool.
//   Channel  Signals                       Direction  Beat taken when
//   command  start, busy, cmd_in           in         start && !busy
//   result   done, result                  out        done high
//   config   cfg_we, cfg_index, cfg_data   in         cfg_we high
// A release or unused command passes through the decode and done states only.
// An acquire checks entries in turn until one matches, then shifts the rest down.
// A tick checks every entry in a purge pass once the oldest reaches the purge age.
// Entries are walked one at a time through the single read port of the list memory.
// Reset clears all counters and totals; the receiver cannot stall.
module idle_buffer_recycle_pool import ibrp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_beat_t    cmd_in,
    output logic        done,
    output out_beat_t   result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    ibrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dstat),
        .busy  (busy),
        .cmd   (dcmd)
    );

    ibrp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (cmd_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dcmd),
        .stat      (dstat),
        .done      (done),
        .result    (result)
    );

endmodule

>>> rtl/ibrp_checker.sv
// Port-level checker for the buffer recycle pool, bound to the top level.
module ibrp_checker import ibrp_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_beat_t result
);

    // A beat taken makes the block busy next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // Results come only at the end of busy work.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside work");

    // One result per beat: done is a single pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The idle count never passes the list size.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.idle_count <= 5'(POOL_ENTRIES))
        else $error("idle count out of range");

    // Status codes stay in range.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_TICK)
        else $error("bad status code");

endmodule

bind idle_buffer_recycle_pool ibrp_checker u_ibrp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> bench/idle_buffer_recycle_pool_checker.sv
// Checker for the buffer recycle pool: predicts every result beat and compares it.
`timescale 1ns / 100ps

module idle_buffer_recycle_pool_checker import ibrp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_beat_t    cmd_in,
    input  logic        done,
    input  out_beat_t   result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    // Predicted state of the pool.
    typedef struct {
        logic [15:0] hnd;
        logic [31:0] size;
        logic        dyn;
        logic [31:0] when;
    } pool_entry_t;

    pool_entry_t pool_list[POOL_ENTRIES];
    int          pool_fill;
    logic [31:0] clock_ticks;
    logic [32:0] oldest_tick;
    logic [47:0] live_bytes;
    logic [47:0] pooled_bytes;
    logic [15:0] live_buffers;
    logic [15:0] handle_counter;
    logic [31:0] idle_cap;
    logic [15:0] age_limit;
    out_beat_t   answer_queue[$];

    assign pending = answer_queue.size();

    function automatic logic [47:0] floor_sub_bytes(logic [47:0] a, logic [31:0] b);
        return (a > {16'd0, b}) ? a - {16'd0, b} : 48'd0;
    endfunction

    // Remove a dropped or purged buffer from the live totals.
    function automatic void retire_live(logic [31:0] size);
        live_bytes   = floor_sub_bytes(live_bytes, size);
        live_buffers = (live_buffers > 0) ? live_buffers - 16'd1 : 16'd0;
    endfunction

    function automatic logic [47:0] add_bytes_sat(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? SAT48 : s[47:0];
    endfunction

    // Drop every aged entry once the oldest one has reached the purge age.
    function automatic logic [4:0] purge_aged();
        int kept;
        logic [4:0] gone;
        kept = 0;
        gone = 0;
        if (oldest_tick == NONE33 || ({1'b0, clock_ticks} - oldest_tick) < {17'd0, age_limit})
            return 5'd0;
        oldest_tick = NONE33;
        for (int i = 0; i < pool_fill; i++) begin
            if (clock_ticks - pool_list[i].when >= {16'd0, age_limit}) begin
                pooled_bytes = floor_sub_bytes(pooled_bytes, pool_list[i].size);
                retire_live(pool_list[i].size);
                gone++;
            end
            else begin
                if ({1'b0, pool_list[i].when} < oldest_tick)
                    oldest_tick = {1'b0, pool_list[i].when};
                pool_list[kept] = pool_list[i];
                kept++;
            end
        end
        pool_fill = kept;
        return gone;
    endfunction

    // Work out the answer for one command beat.
    function automatic out_beat_t predict_answer(in_beat_t b);
        out_beat_t o;
        logic [32:0] t;
        int hit;
        o = '0;
        o.status = ST_TICK;
        case (cmd_t'(b.command))
            CMD_TICK:
            begin
                t = {1'b0, clock_ticks} + {17'd0, b.elapsed};
                clock_ticks = t[32] ? MAX32 : t[31:0];
                if (age_limit != 0)
                    o.purged = purge_aged();
            end
            CMD_ACQUIRE:
            begin
                hit = -1;
                for (int i = 0; i < pool_fill; i++)
                    if (hit < 0 && pool_list[i].dyn == b.dynamic
                        && pool_list[i].size >= b.request_size)
                        hit = i;
                if (hit >= 0) begin
                    o.result_handle = pool_list[hit].hnd;
                    pooled_bytes = floor_sub_bytes(pooled_bytes, pool_list[hit].size);
                    for (int i = hit; i + 1 < pool_fill; i++)
                        pool_list[i] = pool_list[i + 1];
                    pool_fill--;
                    o.status = ST_REUSED;
                end
                else begin
                    o.result_handle = handle_counter;
                    handle_counter = handle_counter + 16'd1;
                    live_bytes = add_bytes_sat(live_bytes, b.request_size);
                    if (live_buffers != 16'hFFFF)
                        live_buffers++;
                    o.status = ST_NEW;
                end
            end
            CMD_RELEASE:
            begin
                if ((idle_cap != 0 && ({1'b0, pooled_bytes} + {17'd0, b.request_size})
                        > {17'd0, idle_cap}) || pool_fill >= POOL_ENTRIES) begin
                    retire_live(b.request_size);
                    o.status = ST_DROPPED;
                end
                else begin
                    pool_list[pool_fill] = '{b.handle, b.request_size, b.dynamic, clock_ticks};
                    pool_fill++;
                    pooled_bytes = add_bytes_sat(pooled_bytes, b.request_size);
                    if ({1'b0, clock_ticks} < oldest_tick)
                        oldest_tick = {1'b0, clock_ticks};
                    o.status = ST_KEPT;
                end
            end
            default: ;
        endcase
        o.total_bytes = live_bytes;
        o.idle_bytes  = pooled_bytes;
        o.idle_count  = pool_fill[4:0];
        o.live_count  = live_buffers;
        return o;
    endfunction

    // Watch the channels: register writes, accepted commands, result beats.
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n) begin
            pool_fill      = 0;
            clock_ticks    = 0;
            oldest_tick    = NONE33;
            live_bytes     = 0;
            pooled_bytes   = 0;
            live_buffers   = 0;
            handle_counter = 0;
            idle_cap       = 0;
            age_limit      = PURGE_AGE_RESET;
            fail_count     = 0;
            answer_queue.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_MAX_IDLE)
                    idle_cap = cfg_data;
                else
                    age_limit = cfg_data[15:0];
            end
            if (done) begin
                if (answer_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $realtime, result);
                    fail_count++;
                end
                else begin
                    want = answer_queue.pop_front();
                    if (result !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $realtime, want, result);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                answer_queue = {answer_queue, predict_answer(cmd_in)};
        end
    end

endmodule

>>> bench/idle_buffer_recycle_pool_tb.sv
// Testbench top for the buffer recycle pool: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module idle_buffer_recycle_pool_tb;
    import ibrp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_beat_t    cmd_in;
    logic        done;
    out_beat_t   result;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          beats_sent;
    bit          allow_gaps;
    logic [15:0] released_handles[$];

    idle_buffer_recycle_pool u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    idle_buffer_recycle_pool_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Send one command beat and wait until it is taken.
    task automatic send_beat(in_beat_t b);
        if (allow_gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(posedge clk);
        start  <= 1'b1;
        cmd_in <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        beats_sent++;
        // The block is busy for the next cycle anyway, so start stays low there.
        @(posedge clk);
    endtask

    task automatic send_cmd(cmd_t c, logic [15:0] el, logic [31:0] sz, logic dy,
                            logic [15:0] h);
        in_beat_t b;
        b.command      = c;
        b.elapsed      = el;
        b.request_size = sz;
        b.dynamic      = dy;
        b.handle       = h;
        send_beat(b);
    endtask

    // Write a register once every result has come back.
    task automatic write_reg(logic idx, logic [31:0] val);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Size mostly small, so reuse and the cap both come into play.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // One random beat, mostly well-formed acquire and release traffic.
    task automatic random_beat();
        in_beat_t b;
        int pick;
        b = in_beat_t'({$urandom(), $urandom(), $urandom()});
        pick = $urandom_range(0, 99);
        b.request_size = pick_size();
        if (pick < 35) begin
            b.command = CMD_ACQUIRE;
        end
        else if (pick < 75) begin
            b.command = CMD_RELEASE;
            if (released_handles.size() != 0 && $urandom_range(0, 1))
                b.handle = released_handles[$urandom_range(0, released_handles.size() - 1)];
        end
        else if (pick < 97) begin
            b.command = CMD_TICK;
            b.elapsed = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                    : 16'($urandom_range(0, 6));
        end
        else begin
            b.command = CMD_NONE;
        end
        send_beat(b);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd_in      = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MAX_IDLE;
        cfg_data    = '0;
        beats_sent  = 0;
        allow_gaps  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: new handles, reuse by kind and size, unused command, fill, overflow and purge ticks.
        send_cmd(CMD_ACQUIRE, 16'h0, 32'hFFFF_FFFF, 1'b1, 16'h0);
        send_cmd(CMD_ACQUIRE, 16'hFFFF, 32'h0, 1'b0, 16'hFFFF);
        send_cmd(CMD_RELEASE, 16'h0, 32'd100, 1'b0, 16'hFFFF);
        send_cmd(CMD_RELEASE, 16'h0, 32'hFFFF_FFFF, 1'b1, 16'h0);
        send_cmd(CMD_ACQUIRE, 16'h0, 32'd200, 1'b0, 16'h0);
        send_cmd(CMD_ACQUIRE, 16'h0, 32'd50, 1'b1, 16'h0);
        send_cmd(CMD_ACQUIRE, 16'h0, 32'd50, 1'b0, 16'h0);
        send_cmd(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        for (int i = 0; i < 17; i++)
            send_cmd(CMD_RELEASE, 16'h0, 32'(i), i[0], 16'(i));
        send_cmd(CMD_TICK, 16'd9, 32'h0, 1'b0, 16'h0);
        send_cmd(CMD_TICK, 16'd1, 32'h0, 1'b0, 16'h0);
        send_cmd(CMD_TICK, 16'hFFFF, 32'h0, 1'b0, 16'h0);

        // Random phases across several register settings, the extremes among them.
        allow_gaps = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(REG_MAX_IDLE, 32'd0);   write_reg(REG_PURGE_AGE, 32'd0); end
                1: begin write_reg(REG_MAX_IDLE, 32'd1000); write_reg(REG_PURGE_AGE, 32'd3); end
                2: begin write_reg(REG_MAX_IDLE, 32'hFFFF_FFFF);
                         write_reg(REG_PURGE_AGE, 32'hFFFF); end
                3: begin write_reg(REG_MAX_IDLE, 32'd1);   write_reg(REG_PURGE_AGE, 32'd1); end
                4: begin write_reg(REG_MAX_IDLE, $urandom()); write_reg(REG_PURGE_AGE, $urandom()); end
                5: begin write_reg(REG_MAX_IDLE, 32'd0);   write_reg(REG_PURGE_AGE, 32'd10); end
                6: begin write_reg(REG_MAX_IDLE, 32'd600); write_reg(REG_PURGE_AGE, 32'd2); end
                default: begin write_reg(REG_MAX_IDLE, 32'd0); write_reg(REG_PURGE_AGE, 32'd5); end
            endcase
            allow_gaps = (phase != 7);
            for (int k = 0; k < 210; k++) begin
                random_beat();
                if ($urandom_range(0, 7) == 0)
                    released_handles = {released_handles, 16'($urandom())};
            end
        end

        // Drain and give the verdict.
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Sent %0d command beats over eight register settings,", beats_sent);
        $display("covering reuse, new handles, drops, purges and saturation.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ibrp_pkg.sv
rtl/ibrp_ram.sv
rtl/ibrp_ctrl.sv
rtl/ibrp_dp.sv
rtl/idle_buffer_recycle_pool.sv
rtl/ibrp_checker.sv
bench/idle_buffer_recycle_pool_checker.sv
bench/idle_buffer_recycle_pool_tb.sv
